// ===== rtl/acr_pkg.sv =====
// acr_pkg: shared types, constants and helper functions for the tilt and creep-rate block
// no dependencies; imported by acr_cordic and by the top level
package acr_pkg;

    typedef logic signed [33:0] vec_t;
    typedef logic signed [25:0] ang_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_SQ1_GO,
        ST_SQ1_WAIT,
        ST_PITCH_GO,
        ST_PITCH_WAIT,
        ST_ROLL_GO,
        ST_ROLL_WAIT,
        ST_SQ2_GO,
        ST_SQ2_WAIT,
        ST_TILT_GO,
        ST_TILT_WAIT,
        ST_CRP_GO,
        ST_CRP_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } acr_state_t;

    localparam logic [1:0] REG_PRESENT  = 2'd0;
    localparam logic [1:0] REG_OFFSET_X = 2'd1;
    localparam logic [1:0] REG_OFFSET_Y = 2'd2;
    localparam logic [1:0] REG_OFFSET_Z = 2'd3;

    localparam logic [16:0] RATE_K        = 17'd117342;
    localparam logic [16:0] CREEP_K       = 17'd60000;
    localparam logic [15:0] FALLBACK_TILT = 16'd5120;
    localparam logic signed [15:0] ONE_G  = 16'sd8192;
    localparam logic signed [17:0] PITCH_MAX = 18'sd23040;
    localparam logic signed [17:0] ROLL_MAX  = 18'sd46080;
    localparam logic signed [17:0] TILT_MAX  = 18'sd46080;
    localparam logic [41:0] WEAK_LIMIT    = 42'd67108864;
    localparam logic [31:0] DT_MIN        = 32'd6;
    localparam ang_t ANG_QUARTER          = 26'sd5898240;
    localparam int MAX_STEPS              = 24;

    // atan(2^-i) in degrees * 2^16
    function automatic ang_t atan_entry(input logic [4:0] i);
        ang_t v;
        case (i)
            5'd0:  v = 26'sd2949120;
            5'd1:  v = 26'sd1740967;
            5'd2:  v = 26'sd919879;
            5'd3:  v = 26'sd466945;
            5'd4:  v = 26'sd234379;
            5'd5:  v = 26'sd117304;
            5'd6:  v = 26'sd58666;
            5'd7:  v = 26'sd29335;
            5'd8:  v = 26'sd14668;
            5'd9:  v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            5'd20: v = 26'sd4;
            5'd21: v = 26'sd2;
            5'd22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767)
            r = 16'sh7fff;
        else if (v < -17'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // degrees * 2^16 down to 256 per degree, half away from zero
    function automatic logic signed [17:0] deg_round(input ang_t a);
        logic signed [26:0] ax;
        logic signed [26:0] t;
        ax = 27'(a);
        if (ax >= 0)
            t = (ax + 27'sd128) >>> 8;
        else
            t = -((-ax + 27'sd128) >>> 8);
        return t[17:0];
    endfunction

    function automatic logic [16:0] mag17(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = 17'(v);
        return (e < 0) ? 17'(-e) : 17'(e);
    endfunction

endpackage

// ===== rtl/acr_mul.sv =====
// acr_mul: unsigned 17 x 17 shift-add multiplier, one multiplier bit per cycle
// depends on nothing but clk and rst_n
module acr_mul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [16:0] a,
    input  logic [16:0] b,
    output logic        done,
    output logic [33:0] prod
);
    logic [16:0] a_reg;
    logic [34:0] p_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [17:0] sum;

    assign sum = p_reg[34:17] + (p_reg[0] ? {1'b0, a_reg} : 18'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            p_reg <= {18'd0, b};
        end
        else if (busy_reg)
            p_reg <= {1'b0, sum, p_reg[16:1]};
    end

    assign done = done_reg;
    assign prod = p_reg[33:0];
endmodule

// ===== rtl/acr_isqrt.sv =====
// acr_isqrt: floor(sqrt(n * 2^28)), one root bit per cycle
// depends on nothing but clk and rst_n
module acr_isqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] n,
    output logic        done,
    output logic [29:0] root
);
    logic [59:0] rad_reg;
    logic [31:0] rem_reg;
    logic [29:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] cur;
    logic [33:0] trial;

    assign cur   = {rem_reg, rad_reg[59:58]};
    assign trial = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd29)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= {n, 28'd0};
            rem_reg  <= 32'd0;
            root_reg <= 30'd0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[57:0], 2'b00};
            if (cur >= trial)
            begin
                rem_reg  <= 32'(cur - trial);
                root_reg <= {root_reg[28:0], 1'b1};
            end
            else
            begin
                rem_reg  <= cur[31:0];
                root_reg <= {root_reg[28:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== rtl/acr_cordic.sv =====
// acr_cordic: vectoring cordic giving atan2(y, x) in degrees * 2^16, one rotation per cycle
// depends on acr_pkg for the arctangent table and vector types
module acr_cordic #(
    parameter int STEPS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  acr_pkg::vec_t x_in,
    input  acr_pkg::vec_t y_in,
    output logic          done,
    output acr_pkg::ang_t angle
);
    import acr_pkg::*;

    localparam int CNT_W = $clog2(STEPS);

    vec_t x_reg;
    vec_t y_reg;
    ang_t z_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;
    vec_t dx;
    vec_t dy;

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                if (x_in == 0 && y_in == 0)
                    done_reg <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // left half plane: rotate by a quarter turn first
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg <= y_in;
                    y_reg <= -x_in;
                    z_reg <= ANG_QUARTER;
                end
                else
                begin
                    x_reg <= -y_in;
                    y_reg <= x_in;
                    z_reg <= -ANG_QUARTER;
                end
            end
            else
            begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_entry(5'(cnt_reg));
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_entry(5'(cnt_reg));
            end
        end
    end

    assign done  = done_reg;
    assign angle = z_reg;
endmodule

// ===== rtl/acr_div.sv =====
// acr_div: unsigned 32 / 32 restoring divider, one quotient bit per cycle
// depends on nothing but clk and rst_n
module acr_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quot
);
    logic [31:0] rem_reg;
    logic [31:0] q_reg;
    logic [31:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] t;

    assign t = {rem_reg, q_reg[31]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 32'd0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (t >= {1'b0, den_reg})
            begin
                rem_reg <= 32'(t - {1'b0, den_reg});
                q_reg   <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= t[31:0];
                q_reg   <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

// ===== rtl/accel_tilt_and_creep_rate_top.sv =====
// Tilt inclinometer with creep-rate output. One sample item in gives one result item out.
// Items are handled one at a time by a sequencer over four shared bit-serial units: a 17x17
// shift-add multiplier (squares, gyro scaling, creep scaling), a square root unit, a cordic
// and a 32-bit divider. The divide is skipped when no creep rate is due, and the second
// square root and the tilt cordic when gravity is weak. A finished result waits in an output
// register, so the next item is taken while it is still pending.
// depends on acr_pkg, acr_mul, acr_isqrt, acr_cordic, acr_div
module accel_tilt_and_creep_rate_top #(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // acc_x, acc_y, acc_z, rot_x, rot_y, rot_z, time_ms
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // corr_x, corr_y, corr_z, rate_x_dps, rate_y_dps, rate_z_dps, pitch_angle,
    // roll_angle, tilt_angle, creep_rate, 4 zero bits
    output logic [183:0] m_axis_tdata
);
    import acr_pkg::*;

    acr_state_t state_reg, state_next;

    logic        present_reg;
    logic [15:0] offset_reg [3];

    logic signed [15:0] c_reg [3];
    logic signed [15:0] rot_reg [3];
    logic signed [16:0] rate_reg [3];
    logic [30:0]        sq_reg [3];
    logic [31:0]        time_reg;
    logic [29:0]        r_reg;
    logic signed [17:0] pitch_reg;
    logic signed [17:0] roll_reg;
    logic [15:0]        tilt_reg;
    logic [31:0]        creep_reg;
    logic [31:0]        prod_reg;
    logic               neg_reg;
    logic [2:0]         job_reg;
    logic [15:0]        last_tilt_reg;
    logic [31:0]        last_time_reg;
    logic               out_valid_reg;
    logic [183:0]       out_data_reg;

    logic mul_go, sq_go, cor_go, div_go;
    logic mul_done, sq_done, cor_done, div_done;
    logic [16:0] mul_a, mul_b;
    logic [33:0] mul_p;
    logic [31:0] sq_n;
    logic [29:0] sq_root;
    vec_t cor_x, cor_y;
    ang_t cor_z;
    logic [31:0] div_q;

    logic in_take;
    logic cfg_write;
    logic out_free;
    logic signed [16:0] diff;
    logic [31:0] dt;
    logic creep_ok;
    logic [32:0] g_sum;
    logic [41:0] g_scaled;
    logic grav_ok;
    logic signed [17:0] ang_r;
    logic [17:0] rate_mag;
    logic signed [15:0] mul_src;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        case (paddr[3:2])
            REG_PRESENT:  prdata = {31'd0, present_reg};
            REG_OFFSET_X: prdata = {16'd0, offset_reg[0]};
            REG_OFFSET_Y: prdata = {16'd0, offset_reg[1]};
            REG_OFFSET_Z: prdata = {16'd0, offset_reg[2]};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= 1'b0;
            offset_reg[0] <= 16'd0;
            offset_reg[1] <= 16'd0;
            offset_reg[2] <= 16'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_PRESENT:  present_reg   <= pwdata[0];
                REG_OFFSET_X: offset_reg[0] <= pwdata[15:0];
                REG_OFFSET_Y: offset_reg[1] <= pwdata[15:0];
                REG_OFFSET_Z: offset_reg[2] <= pwdata[15:0];
                default:      present_reg   <= present_reg;
            endcase
        end
    end

    // shared datapath helpers
    assign diff     = signed'({1'b0, tilt_reg}) - signed'({1'b0, last_tilt_reg});
    assign dt       = time_reg - last_time_reg;
    assign creep_ok = (dt > DT_MIN) && (last_time_reg != 32'd0);
    assign g_sum    = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
    // times 400 = 256 + 128 + 16
    assign g_scaled = {1'b0, g_sum, 8'd0} + {2'b00, g_sum, 7'd0} + {5'd0, g_sum, 4'd0};
    assign grav_ok  = g_scaled > WEAK_LIMIT;
    assign ang_r    = deg_round(cor_z);
    assign rate_mag = 18'(mul_p[31:0] + 34'd32768 >> 16);

    always_comb
    begin
        if (job_reg < 3'd3)
            mul_src = c_reg[2'(job_reg)];
        else if (job_reg < 3'd6)
            mul_src = rot_reg[2'(job_reg - 3'd3)];
        else
            mul_src = '0;
    end

    always_comb
    begin
        if (state_reg == ST_CRP_GO)
        begin
            mul_a = (diff < 0) ? 17'(-diff) : 17'(diff);
            mul_b = CREEP_K;
        end
        else
        begin
            mul_a = mag17(mul_src);
            mul_b = (job_reg < 3'd3) ? mag17(mul_src) : RATE_K;
        end
    end

    assign sq_n = (state_reg == ST_SQ1_GO) ? 32'(sq_reg[0]) + 32'(sq_reg[2])
                                           : 32'(sq_reg[0]) + 32'(sq_reg[1]);

    always_comb
    begin
        case (state_reg)
            ST_PITCH_GO:
            begin
                cor_x = vec_t'({4'd0, r_reg});
                cor_y = vec_t'({{4{c_reg[1][15]}}, c_reg[1], 14'd0});
            end
            ST_ROLL_GO:
            begin
                cor_x = vec_t'({{4{c_reg[2][15]}}, c_reg[2], 14'd0});
                cor_y = -vec_t'({{4{c_reg[0][15]}}, c_reg[0], 14'd0});
            end
            default:
            begin
                cor_x = vec_t'({{4{c_reg[2][15]}}, c_reg[2], 14'd0});
                cor_y = vec_t'({4'd0, r_reg});
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mul_go = 1'b0;
        sq_go  = 1'b0;
        cor_go = 1'b0;
        div_go = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (in_take)
                    state_next = present_reg ? ST_MUL_GO : ST_CRP_GO;
            ST_MUL_GO:
            begin
                mul_go = 1'b1;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
                if (mul_done)
                    state_next = (job_reg == 3'd5) ? ST_SQ1_GO : ST_MUL_GO;
            ST_SQ1_GO:
            begin
                sq_go = 1'b1;
                state_next = ST_SQ1_WAIT;
            end
            ST_SQ1_WAIT:
                if (sq_done)
                    state_next = ST_PITCH_GO;
            ST_PITCH_GO:
            begin
                cor_go = 1'b1;
                state_next = ST_PITCH_WAIT;
            end
            ST_PITCH_WAIT:
                if (cor_done)
                    state_next = ST_ROLL_GO;
            ST_ROLL_GO:
            begin
                cor_go = 1'b1;
                state_next = ST_ROLL_WAIT;
            end
            ST_ROLL_WAIT:
                if (cor_done)
                    state_next = grav_ok ? ST_SQ2_GO : ST_CRP_GO;
            ST_SQ2_GO:
            begin
                sq_go = 1'b1;
                state_next = ST_SQ2_WAIT;
            end
            ST_SQ2_WAIT:
                if (sq_done)
                    state_next = ST_TILT_GO;
            ST_TILT_GO:
            begin
                cor_go = 1'b1;
                state_next = ST_TILT_WAIT;
            end
            ST_TILT_WAIT:
                if (cor_done)
                    state_next = ST_CRP_GO;
            ST_CRP_GO:
            begin
                mul_go = 1'b1;
                state_next = ST_CRP_WAIT;
            end
            ST_CRP_WAIT:
                if (mul_done)
                    state_next = creep_ok ? ST_DIV_GO : ST_FINISH;
            ST_DIV_GO:
            begin
                div_go = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
                if (div_done)
                    state_next = ST_FINISH;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_take)
                begin
                    job_reg  <= 3'd0;
                    time_reg <= s_axis_tdata[127:96];
                    rot_reg[0] <= s_axis_tdata[63:48];
                    rot_reg[1] <= s_axis_tdata[79:64];
                    rot_reg[2] <= s_axis_tdata[95:80];
                    pitch_reg <= '0;
                    roll_reg  <= '0;
                    rate_reg[0] <= '0;
                    rate_reg[1] <= '0;
                    rate_reg[2] <= '0;
                    if (present_reg)
                    begin
                        c_reg[0] <= sat16(17'(signed'(s_axis_tdata[15:0]))
                                          - 17'(signed'(offset_reg[0])));
                        c_reg[1] <= sat16(17'(signed'(s_axis_tdata[31:16]))
                                          - 17'(signed'(offset_reg[1])));
                        c_reg[2] <= sat16(17'(signed'(s_axis_tdata[47:32]))
                                          - 17'(signed'(offset_reg[2])));
                        tilt_reg <= 16'd0;
                    end
                    else
                    begin
                        c_reg[0] <= '0;
                        c_reg[1] <= '0;
                        c_reg[2] <= ONE_G;
                        tilt_reg <= FALLBACK_TILT;
                    end
                end
            ST_MUL_WAIT:
                if (mul_done)
                begin
                    job_reg <= job_reg + 3'd1;
                    if (job_reg < 3'd3)
                        sq_reg[2'(job_reg)] <= mul_p[30:0];
                    else if (mul_src < 0)
                        rate_reg[2'(job_reg - 3'd3)] <= 17'(-signed'(rate_mag));
                    else
                        rate_reg[2'(job_reg - 3'd3)] <= 17'(rate_mag);
                end
            ST_SQ1_WAIT, ST_SQ2_WAIT:
                if (sq_done)
                    r_reg <= sq_root;
            ST_PITCH_WAIT:
                if (cor_done)
                begin
                    if (ang_r > PITCH_MAX)
                        pitch_reg <= PITCH_MAX;
                    else if (ang_r < -PITCH_MAX)
                        pitch_reg <= -PITCH_MAX;
                    else
                        pitch_reg <= ang_r;
                end
            ST_ROLL_WAIT:
                if (cor_done)
                begin
                    if (ang_r > ROLL_MAX)
                        roll_reg <= ROLL_MAX;
                    else if (ang_r < -ROLL_MAX)
                        roll_reg <= -ROLL_MAX;
                    else
                        roll_reg <= ang_r;
                end
            ST_TILT_WAIT:
                if (cor_done)
                begin
                    if (ang_r > TILT_MAX)
                        tilt_reg <= TILT_MAX[15:0];
                    else if (ang_r < 0)
                        tilt_reg <= 16'd0;
                    else
                        tilt_reg <= ang_r[15:0];
                end
            ST_CRP_WAIT:
                if (mul_done)
                begin
                    prod_reg  <= mul_p[31:0];
                    neg_reg   <= (diff < 0);
                    creep_reg <= 32'd0;
                end
            ST_DIV_WAIT:
                if (div_done)
                    creep_reg <= neg_reg ? -div_q : div_q;
            default:
                job_reg <= job_reg;
        endcase
    end

    // history and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_tilt_reg <= 16'd0;
            last_time_reg <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_FINISH && out_free)
            begin
                last_tilt_reg <= tilt_reg;
                last_time_reg <= time_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && out_free)
            out_data_reg <= {4'd0, creep_reg, tilt_reg, roll_reg[16:0], pitch_reg[15:0],
                             rate_reg[2], rate_reg[1], rate_reg[0],
                             c_reg[2], c_reg[1], c_reg[0]};
    end

    acr_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_p)
    );

    acr_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_go),
        .n     (sq_n),
        .done  (sq_done),
        .root  (sq_root)
    );

    acr_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_go),
        .x_in  (cor_x),
        .y_in  (cor_y),
        .done  (cor_done),
        .angle (cor_z)
    );

    acr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go),
        .num   (prod_reg),
        .den   (dt),
        .done  (div_done),
        .quot  (div_q)
    );

    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mul_go, sq_go, cor_go, div_go}))
        else $error("two units started together");

    a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg != ST_IDLE)
        else $error("sequencer stayed idle after taking an item");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> out_valid_reg)
        else $error("result not loaded at finish");

    a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH |-> tilt_reg <= TILT_MAX[15:0])
        else $error("tilt out of range");

endmodule
